@@ hw/rtl/imsu_pkg.sv @@
// ----------------------------------------------------------------------------
// imsu_pkg - shared constants for the Ising Metropolis spin update block
// Lattice geometry, register map, threshold reset values and the reset
// values of the magnetization and energy totals.
// ----------------------------------------------------------------------------
package imsu_pkg;

  // Lattice geometry: square side, a power of two set by the coordinate width
  localparam int COORD_W      = 7;
  localparam int LATTICE_SIDE = 2 ** COORD_W;
  localparam int CELL_W       = 2 * COORD_W;
  localparam int CELLS        = LATTICE_SIDE * LATTICE_SIDE;

  // Payload widths
  localparam int RAND_W   = 16;
  localparam int DE_W     = 5;
  localparam int MAG_W    = 16;
  localparam int ENERGY_W = 17;

  // Threshold register map
  localparam int THR_W     = 16;
  localparam int NUM_THR   = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_THR_DE2  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE4  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE6  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE8  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DE10 = 3'd4;

  localparam logic [THR_W-1:0] THR_RESET [NUM_THR] = '{
    16'd43930, 16'd29447, 16'd19739, 16'd13231, 16'd8869
  };

  // Totals for an all-up lattice with open boundaries, J = 1, H = 1
  localparam int MAG_RESET_INT    = CELLS;
  localparam int ENERGY_RESET_INT =
    -(2 * LATTICE_SIDE * (LATTICE_SIDE - 1)) - LATTICE_SIDE * LATTICE_SIDE;

  localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(MAG_RESET_INT);
  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(ENERGY_RESET_INT);

endpackage

@@ hw/rtl/ising_metropolis_spin_update.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update - single-site Metropolis update, 2D Ising
// An input beat steps through UP, DOWN, LEFT, RIGHT, LAST and DECIDE;
// the result is registered from DECIDE once the output is free. A new
// proposal waits for the four neighbor reads and the write-back through
// the single-port lattice memory. Reset: a clearing pass sets every spin
// up; input is stalled meanwhile, threshold writes are taken at any time.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_write,
  input  logic [imsu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [imsu_pkg::THR_W-1:0]            cfg_data,
  // proposal channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [imsu_pkg::COORD_W-1:0]          site_column,
  input  logic [imsu_pkg::COORD_W-1:0]          site_row,
  input  logic [imsu_pkg::RAND_W-1:0]           random_fraction,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  flipped,
  output logic                                  site_spin,
  output logic signed [imsu_pkg::DE_W-1:0]      energy_change,
  output logic signed [imsu_pkg::MAG_W-1:0]     magnetization,
  output logic signed [imsu_pkg::ENERGY_W-1:0]  total_energy
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_UP     = 8'b0000_0100,
    ST_DOWN   = 8'b0000_1000,
    ST_LEFT   = 8'b0001_0000,
    ST_RIGHT  = 8'b0010_0000,
    ST_LAST   = 8'b0100_0000,
    ST_DECIDE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [imsu_pkg::CELL_W-1:0]  clear_addr;
  logic [imsu_pkg::COORD_W-1:0] cur_col;
  logic [imsu_pkg::COORD_W-1:0] cur_row;
  logic [imsu_pkg::RAND_W-1:0]  cur_rand;
  logic                         cur_spin;
  logic                         pend_in;
  logic signed [3:0]            nbr_sum;
  logic signed [3:0]            nbr_delta;

  logic [imsu_pkg::THR_W-1:0]   thr [imsu_pkg::NUM_THR];

  logic signed [imsu_pkg::MAG_W-1:0]    mag_total;
  logic signed [imsu_pkg::ENERGY_W-1:0] energy_total;

  // lattice memory port
  logic                         lat [imsu_pkg::CELLS];
  logic [imsu_pkg::CELL_W-1:0]  mem_addr;
  logic                         mem_we;
  logic                         mem_wdata;
  logic                         mem_rdata;

  logic                         in_beat;
  logic                         out_free;
  logic                         out_load;

  // decision datapath
  logic signed [3:0]            sum_p1;
  logic signed [imsu_pkg::DE_W-1:0] de_mag;
  logic signed [imsu_pkg::DE_W-1:0] de;
  logic                         de_pos;
  logic [2:0]                   thr_sel;
  logic [imsu_pkg::THR_W-1:0]   thr_val;
  logic                         accept;

  assign in_stall = (state != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ST_DECIDE) && out_free;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < imsu_pkg::NUM_THR; i++) begin
        thr[i] <= imsu_pkg::THR_RESET[i];
      end
    end else if (cfg_write && (cfg_index < imsu_pkg::CFG_IDX_W'(imsu_pkg::NUM_THR))) begin
      thr[cfg_index] <= cfg_data;
    end
  end

  // Lattice memory, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lat[mem_addr] <= mem_wdata;
    end
    mem_rdata <= lat[mem_addr];
  end

  // Neighbor contribution of the word read last cycle
  always_comb begin
    if (pend_in) begin
      nbr_delta = mem_rdata ? 4'sd1 : -4'sd1;
    end else begin
      nbr_delta = 4'sd0;
    end
  end

  // Form dE = 2*s*(sum+1) and pick the threshold for positive dE
  always_comb begin
    sum_p1  = nbr_sum + 4'sd1;
    de_mag  = {sum_p1, 1'b0};
    de      = cur_spin ? de_mag : -de_mag;
    de_pos  = !de[imsu_pkg::DE_W-1] && (de != '0);
    thr_sel = de[3:1] - 3'd1;
    thr_val = (thr_sel < 3'(imsu_pkg::NUM_THR)) ? thr[thr_sel] : '0;
    accept  = de_pos ? (cur_rand < thr_val) : 1'b1;
  end

  // Memory address, write enable and next state
  always_comb begin
    state_next = state;
    mem_addr   = {cur_row, cur_col};
    mem_we     = 1'b0;
    mem_wdata  = !cur_spin;
    unique case (state)
      ST_CLEAR: begin
        mem_addr  = clear_addr;
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        if (clear_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = {site_row, site_column};
        if (in_beat) begin
          state_next = ST_UP;
        end
      end
      ST_UP: begin
        mem_addr   = {cur_row - 1'b1, cur_col};
        state_next = ST_DOWN;
      end
      ST_DOWN: begin
        mem_addr   = {cur_row + 1'b1, cur_col};
        state_next = ST_LEFT;
      end
      ST_LEFT: begin
        mem_addr   = {cur_row, cur_col - 1'b1};
        state_next = ST_RIGHT;
      end
      ST_RIGHT: begin
        mem_addr   = {cur_row, cur_col + 1'b1};
        state_next = ST_LAST;
      end
      ST_LAST: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        mem_we = out_load && accept;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
    end
  end

  // Proposal registers and neighbor accumulator
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cur_col  <= site_column;
      cur_row  <= site_row;
      cur_rand <= random_fraction;
    end
    unique case (state)
      ST_UP: begin
        cur_spin <= mem_rdata;
        nbr_sum  <= 4'sd0;
        pend_in  <= (cur_row != '0);
      end
      ST_DOWN: begin
        nbr_sum <= nbr_sum + nbr_delta;
        pend_in <= (cur_row != '1);
      end
      ST_LEFT: begin
        nbr_sum <= nbr_sum + nbr_delta;
        pend_in <= (cur_col != '0);
      end
      ST_RIGHT: begin
        nbr_sum <= nbr_sum + nbr_delta;
        pend_in <= (cur_col != '1);
      end
      ST_LAST: begin
        nbr_sum <= nbr_sum + nbr_delta;
        pend_in <= 1'b0;
      end
      default: begin
        pend_in <= 1'b0;
      end
    endcase
  end

  // Magnetization and energy totals
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_total    <= imsu_pkg::MAG_RESET;
      energy_total <= imsu_pkg::ENERGY_RESET;
    end else if (out_load && accept) begin
      mag_total    <= mag_total + (cur_spin ? -16'sd2 : 16'sd2);
      energy_total <= energy_total +
                      {{(imsu_pkg::ENERGY_W - imsu_pkg::DE_W){de[imsu_pkg::DE_W-1]}}, de};
    end
  end

  // Result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      flipped       <= accept;
      site_spin     <= accept ? !cur_spin : cur_spin;
      energy_change <= de;
      magnetization <= accept ? (mag_total + (cur_spin ? -16'sd2 : 16'sd2)) : mag_total;
      total_energy  <= accept ? (energy_total +
                       {{(imsu_pkg::ENERGY_W - imsu_pkg::DE_W){de[imsu_pkg::DE_W-1]}}, de})
                              : energy_total;
    end
  end

  // A non-positive energy change is always taken
  a_nonpos_flips: assert property (@(posedge clk) disable iff (rst)
    out_valid && (energy_change <= 0) |-> flipped)
    else $error("non-positive energy change reported without a flip");

  // Accumulated neighbor sum stays within four neighbors
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> (nbr_sum <= 4'sd4) && (nbr_sum >= -4'sd4))
    else $error("neighbor sum out of range");

  // Magnetization moves exactly when a flip is reported
  a_mag_follows_flip: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (flipped ? (magnetization != $past(mag_total))
                          : (magnetization == $past(mag_total))))
    else $error("magnetization does not follow flip decision");

  // An input beat always starts the neighbor reads
  a_beat_starts_reads: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == ST_UP))
    else $error("input beat did not start the read sequence");

endmodule
